>>> hdl/ohs_pkg.sv
// shared constants and types for the open-addressing hash set
package ohs_pkg;

    localparam int TableSlots = 256;
    localparam int KeyBytes = 8;
    localparam int SlotW = $clog2(TableSlots);
    localparam int LenW = SlotW + 1;

    typedef logic [SlotW-1:0] slot_t;
    typedef logic [LenW-1:0] len_t;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_OTHER  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MARK_EMPTY  = 2'd0,
        MARK_FILLED = 2'd1,
        MARK_TOMB   = 2'd2,
        MARK_SPARE  = 2'd3
    } mark_t;

endpackage

>>> hdl/open_addressing_hash_set_core.sv
// open-addressing hash set with linear probing, one request at a time
//
// input channel: in_valid/in_stall with req_type and key; output channel:
// out_valid/out_stall with hit, changed, slot_index and element_total.
// cfg_valid/cfg_ready writes table_length (number of active slots).
// a request hashes its key one character per cycle, stopping at a zero
// byte or after eight characters, reduces the hash modulo the length by
// restoring subtraction, then probes slots in turn through the key and
// mark memories (address, registered data); one request is in flight.
// the result sits in an output register; the next request is taken once
// it has been transferred. while out_stall is high the result holds.
// after reset a clearing pass over every slot empties the mark memory;
// no request is taken until it ends. table_length resets to 256.
module open_addressing_hash_set_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        changed,
    output logic [7:0]  slot_index,
    output logic [8:0]  element_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  table_length
);
    import ohs_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_DONE, S_OUT
    } state_t;

    logic [63:0] key_mem [TableSlots];
    mark_t       mark_mem [TableSlots];
    logic [63:0] rd_key;
    mark_t       rd_mark;

    state_t      state_reg;
    req_t        req_reg;
    logic [63:0] key_reg;
    logic [3:0]  byte_reg;
    logic [31:0] hash_reg;
    logic [31:0] rem_reg;
    logic [5:0]  bit_reg;
    len_t        len_reg;
    len_t        cfg_len_reg;
    slot_t       idx_reg;
    len_t        cnt_reg;
    logic        tomb_ok_reg;
    slot_t       tomb_reg;
    logic        free_ok_reg;
    logic        hit_reg;
    slot_t       at_reg;
    len_t        total_reg;
    logic        out_hit_reg;
    logic        out_changed_reg;
    slot_t       out_slot_reg;
    logic        out_valid_reg;

    logic        we_key;
    logic        we_mark;
    slot_t       wa;
    mark_t       wd_mark;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    logic [7:0]  cur_byte;
    slot_t       idx_inc;
    logic [63:0] canon;
    logic        stop;

    always_comb
    begin
        canon = '0;
        stop = 1'b0;
        for (int i = 0; i < KeyBytes; i++)
        begin
            if (key[8*i +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                canon[8*i +: 8] = key[8*i +: 8];
        end
    end

    assign cur_byte  = key_reg[{byte_reg[2:0], 3'b000} +: 8];
    assign rem_shift = {rem_reg, hash_reg[31]};
    assign rem_sub   = rem_shift - {{(33-LenW){1'b0}}, len_reg};
    assign idx_inc   = ({1'b0, idx_reg} + len_t'(1) == len_reg) ? '0 : idx_reg + slot_t'(1);

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign hit = out_hit_reg;
    assign changed = out_changed_reg;
    assign slot_index = 8'(out_slot_reg);
    assign element_total = 9'(total_reg);

    always_ff @(posedge clk)
    begin
        rd_key  <= key_mem[idx_reg];
        rd_mark <= mark_mem[idx_reg];
        if (we_key)
            key_mem[wa] <= key_reg;
        if (we_mark)
            mark_mem[wa] <= wd_mark;
    end

    always_comb
    begin
        we_key = 1'b0;
        we_mark = 1'b0;
        wa = idx_reg;
        wd_mark = MARK_EMPTY;
        if (state_reg == S_CLEAR)
            we_mark = 1'b1;
        else if (state_reg == S_DONE)
        begin
            wa = at_reg;
            if (req_reg == REQ_INSERT && !hit_reg && total_reg < len_reg && free_ok_reg)
            begin
                we_key = 1'b1;
                we_mark = 1'b1;
                wd_mark = MARK_FILLED;
            end
            else if (req_reg == REQ_REMOVE && hit_reg && total_reg != '0)
            begin
                we_mark = 1'b1;
                wd_mark = MARK_TOMB;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            cfg_len_reg <= len_t'(TableSlots);
            total_reg <= '0;
            out_valid_reg <= 1'b0;
            req_reg <= REQ_LOOKUP;
            key_reg <= '0;
            byte_reg <= '0;
            hash_reg <= '0;
            rem_reg <= '0;
            bit_reg <= '0;
            len_reg <= '0;
            cnt_reg <= '0;
            tomb_ok_reg <= 1'b0;
            tomb_reg <= '0;
            free_ok_reg <= 1'b0;
            hit_reg <= 1'b0;
            at_reg <= '0;
            out_hit_reg <= 1'b0;
            out_changed_reg <= 1'b0;
            out_slot_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cfg_len_reg <= table_length;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + slot_t'(1);
                    if (idx_reg == slot_t'(TableSlots - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= req_t'(req_type);
                        key_reg <= canon;
                        byte_reg <= '0;
                        hash_reg <= '0;
                        if (cfg_len_reg == '0)
                            len_reg <= len_t'(1);
                        else if (cfg_len_reg > len_t'(TableSlots))
                            len_reg <= len_t'(TableSlots);
                        else
                            len_reg <= cfg_len_reg;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (byte_reg == 4'(KeyBytes) || cur_byte == 8'd0)
                    begin
                        rem_reg <= '0;
                        bit_reg <= '0;
                        state_reg <= S_MOD;
                    end
                    else
                    begin
                        hash_reg <= (hash_reg << 5) - hash_reg + {24'd0, cur_byte};
                        byte_reg <= byte_reg + 4'd1;
                    end
                end
                S_MOD:
                begin
                    hash_reg <= hash_reg << 1;
                    if (rem_sub[32])
                        rem_reg <= rem_shift[31:0];
                    else
                        rem_reg <= rem_sub[31:0];
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'd31)
                    begin
                        idx_reg <= rem_sub[32] ? slot_t'(rem_shift) : slot_t'(rem_sub);
                        cnt_reg <= '0;
                        tomb_ok_reg <= 1'b0;
                        tomb_reg <= '0;
                        free_ok_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        at_reg <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    priority if (rd_mark == MARK_FILLED && rd_key == key_reg)
                    begin
                        hit_reg <= 1'b1;
                        at_reg <= idx_reg;
                        state_reg <= S_DONE;
                    end
                    else if (rd_mark == MARK_EMPTY || rd_mark == MARK_SPARE)
                    begin
                        free_ok_reg <= 1'b1;
                        at_reg <= tomb_ok_reg ? tomb_reg : idx_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (rd_mark == MARK_TOMB && !tomb_ok_reg)
                        begin
                            tomb_ok_reg <= 1'b1;
                            tomb_reg <= idx_reg;
                        end
                        if (cnt_reg + len_t'(1) == len_reg)
                        begin
                            if (tomb_ok_reg || rd_mark == MARK_TOMB)
                            begin
                                free_ok_reg <= 1'b1;
                                at_reg <= tomb_ok_reg ? tomb_reg : idx_reg;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + len_t'(1);
                            idx_reg <= idx_inc;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_DONE:
                begin
                    out_hit_reg <= hit_reg;
                    out_changed_reg <= we_mark;
                    out_slot_reg <= (hit_reg || we_mark) ? at_reg : '0;
                    if (we_mark)
                        total_reg <= (wd_mark == MARK_FILLED) ? total_reg + len_t'(1)
                                                             : total_reg - len_t'(1);
                    out_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the open-addressing hash set core
module tb_top;
    import ohs_pkg::*;

    localparam int LimitCycles = 3000000;
    localparam int DrainCycles = 600;

    typedef struct {
        logic       hit;
        logic       changed;
        logic [7:0] slot;
        logic [8:0] total;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [63:0] key;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic        changed;
    logic [7:0]  slot_index;
    logic [8:0]  element_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  table_length;

    // golden copy of the set
    logic [63:0] set_key [TableSlots];
    mark_t       set_mark [TableSlots];
    int unsigned set_count;
    int unsigned set_len_reg;

    answer_t     answer_q [$];
    logic [63:0] key_pool [$];
    int          fails;
    int          cycles;
    int          sent;
    int          checked;
    int          hold_cycles;
    int          stall_mode;

    open_addressing_hash_set_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .key(key),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .changed(changed),
        .slot_index(slot_index),
        .element_total(element_total),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .table_length(table_length)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] trim_key(logic [63:0] raw);
        logic [63:0] k;
        k = '0;
        for (int i = 0; i < KeyBytes; i++)
        begin
            if (raw[8*i +: 8] == 8'd0)
                break;
            k[8*i +: 8] = raw[8*i +: 8];
        end
        return k;
    endfunction

    function automatic logic [31:0] string_hash(logic [63:0] k);
        logic [31:0] h;
        h = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (k[8*i +: 8] == 8'd0)
                break;
            h = 32'd31 * h + {24'd0, k[8*i +: 8]};
        end
        return h;
    endfunction

    function automatic answer_t apply_request(logic [1:0] rq, logic [63:0] raw);
        answer_t a;
        logic [63:0] k;
        int unsigned len, home, idx, at, tomb;
        logic found, free_ok, have_tomb;
        k = trim_key(raw);
        len = (set_len_reg == 0) ? 1 : (set_len_reg > TableSlots ? TableSlots : set_len_reg);
        home = string_hash(k) % len;
        found = 0;
        free_ok = 0;
        have_tomb = 0;
        at = 0;
        tomb = 0;
        for (int i = 0; i < len; i++)
        begin
            idx = (home + i) % len;
            if (set_mark[idx] == MARK_FILLED)
            begin
                if (set_key[idx] == k)
                begin
                    found = 1;
                    at = idx;
                    break;
                end
            end
            else if (set_mark[idx] == MARK_TOMB)
            begin
                if (!have_tomb)
                begin
                    have_tomb = 1;
                    tomb = idx;
                end
            end
            else
            begin
                free_ok = 1;
                at = have_tomb ? tomb : idx;
                break;
            end
        end
        if (!found && !free_ok && have_tomb)
        begin
            free_ok = 1;
            at = tomb;
        end
        a.hit = found;
        a.changed = 0;
        a.slot = found ? at[7:0] : 8'd0;
        if (rq == REQ_INSERT)
        begin
            if (!found && set_count < len && free_ok)
            begin
                set_key[at] = k;
                set_mark[at] = MARK_FILLED;
                set_count++;
                a.changed = 1;
                a.slot = at[7:0];
            end
        end
        else if (rq == REQ_REMOVE)
        begin
            if (found && set_count > 0)
            begin
                set_mark[at] = MARK_TOMB;
                set_count--;
                a.changed = 1;
            end
        end
        a.total = set_count[8:0];
        return a;
    endfunction

    // one request transfer; in_valid stays high for the caller to lower
    task automatic send_req(logic [1:0] rq, logic [63:0] k);
        logic taken;
        in_valid <= 1'b1;
        req_type <= rq;
        key <= k;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        answer_q.push_back(apply_request(rq, k));
        sent++;
    endtask

    task automatic pause_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain;
        pause_sender(1);
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_length(int unsigned v);
        logic taken;
        drain();
        cfg_valid <= 1'b1;
        table_length <= v[8:0];
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        set_len_reg = v & 9'h1FF;
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        int n;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0)
            return k;
        n = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++)
        begin
            if (i < n)
                k[8*i +: 8] = 8'($urandom_range(1, 255));
            else if (i == n)
                k[8*i +: 8] = 8'd0;
        end
        // garbage after the terminator stays on some keys
        if ($urandom_range(0, 1) == 0)
            for (int i = n + 1; i < 8; i++)
                k[8*i +: 8] = 8'd0;
        return k;
    endfunction

    function automatic logic [63:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return random_key();
    endfunction

    task automatic test_basic_ops;
        write_length(256);
        send_req(REQ_LOOKUP, 64'd0);
        send_req(REQ_REMOVE, 64'h61);
        send_req(REQ_INSERT, 64'd0);
        send_req(REQ_INSERT, 64'h61);
        send_req(REQ_INSERT, 64'h61);
        send_req(REQ_LOOKUP, 64'hFFFF_FFFF_0000_0061);
        send_req(REQ_OTHER, 64'h61);
        send_req(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(REQ_INSERT, 64'h0101_0101_0101_0101);
        send_req(REQ_REMOVE, 64'h61);
        send_req(REQ_REMOVE, 64'h61);
        send_req(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(REQ_REMOVE, 64'h0101_0101_0101_0101);
        send_req(REQ_REMOVE, 64'd0);
        drain();
    endtask

    task automatic test_tiny_tables;
        write_length(1);
        send_req(REQ_INSERT, 64'h61);
        send_req(REQ_INSERT, 64'h62);
        send_req(REQ_INSERT, 64'h61);
        send_req(REQ_REMOVE, 64'h61);
        send_req(REQ_INSERT, 64'h62);
        send_req(REQ_REMOVE, 64'h62);
        write_length(0);
        send_req(REQ_INSERT, 64'h63);
        send_req(REQ_LOOKUP, 64'h63);
        send_req(REQ_REMOVE, 64'h63);
        write_length(2);
        send_req(REQ_INSERT, 64'h61);
        send_req(REQ_INSERT, 64'h63);
        send_req(REQ_INSERT, 64'h65);
        send_req(REQ_REMOVE, 64'h61);
        send_req(REQ_LOOKUP, 64'h63);
        send_req(REQ_INSERT, 64'h65);
        send_req(REQ_REMOVE, 64'h63);
        send_req(REQ_REMOVE, 64'h65);
        drain();
    endtask

    task automatic test_random_mix(int n, int unsigned len);
        int burst;
        logic [1:0] rq;
        write_length(len);
        key_pool.delete();
        for (int i = 0; i < 24; i++)
            key_pool.push_back(random_key());
        burst = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: rq = REQ_INSERT;
                4, 5, 6:    rq = REQ_REMOVE;
                7, 8:       rq = REQ_LOOKUP;
                default:    rq = 2'($urandom_range(0, 3));
            endcase
            send_req(rq, pick_key());
            burst--;
            if (burst == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    pause_sender($urandom_range(1, 40));
                burst = $urandom_range(1, 12);
            end
        end
        drain();
    endtask

    task automatic test_backpressure;
        write_length(300);
        hold_cycles = 400;
        for (int i = 0; i < 6; i++)
            send_req(2'($urandom_range(0, 3)), pick_key());
        drain();
        write_length(511);
        send_req(REQ_INSERT, 64'h7A7A);
        send_req(REQ_REMOVE, 64'h7A7A);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        key = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        table_length = 9'd256;
        fails = 0;
        sent = 0;
        checked = 0;
        hold_cycles = 0;
        stall_mode = 0;
        set_count = 0;
        set_len_reg = 256;
        for (int i = 0; i < TableSlots; i++)
        begin
            set_mark[i] = MARK_EMPTY;
            set_key[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_tiny_tables();
        test_random_mix(150, 7);
        test_random_mix(150, 256);
        test_random_mix(150, 3);
        test_random_mix(150, 16);
        test_backpressure();

        drain();
        repeat (DrainCycles) @(posedge clk);
        $display("covered %0d requests, %0d results checked, table lengths 0..511 incl. extremes",
                 sent, checked);
        $display("long receiver hold-off with the sender blocked, random gaps and stalls");
        if (fails == 0 && answer_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver: randomly re-picked stall pattern, long hold on request
    always @(posedge clk)
    begin
        if (cycles % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (stall_mode == 0)
            out_stall <= 1'b0;
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 99) < 30);
        else
            out_stall <= ($urandom_range(0, 99) < 75);
    end

    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fails++;
            end
            else
            begin
                a = answer_q.pop_front();
                checked++;
                if (hit !== a.hit)
                begin
                    $error("hit: expected %0d actual %0d", a.hit, hit);
                    fails++;
                end
                if (changed !== a.changed)
                begin
                    $error("changed: expected %0d actual %0d", a.changed, changed);
                    fails++;
                end
                if (slot_index !== a.slot)
                begin
                    $error("slot_index: expected %0d actual %0d", a.slot, slot_index);
                    fails++;
                end
                if (element_total !== a.total)
                begin
                    $error("element_total: expected %0d actual %0d", a.total, element_total);
                    fails++;
                end
            end
        end
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LimitCycles)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

>>> files.f
hdl/ohs_pkg.sv
hdl/open_addressing_hash_set_core.sv
tb/tb_top.sv
